>>> src/fss_pkg.sv
// shared types, constants and helper functions of the fuzzy subsequence scorer
package fss_pkg;

    localparam int PATTERN_MAX = 32;
    localparam int POS_W       = 6;
    localparam int RUN_W       = 6;
    localparam int SCORE_W     = 14;
    localparam int TLEN_W      = 16;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int PATTERN_W   = PATTERN_MAX * 8;

    localparam logic [SCORE_W-1:0] SCORE_MAX   = '1;
    localparam logic [TLEN_W-1:0]  TLEN_MAX    = '1;
    localparam logic [RUN_W-1:0]   RUN_MAX     = '1;
    localparam logic [SCORE_W-1:0] EMPTY_SCORE = 14'd100;
    localparam logic [9:0]         HIT_BONUS   = 10'd10;
    localparam logic [9:0]         EDGE_BONUS  = 10'd20;
    localparam logic [POS_W-1:0]   PLEN_MAX    = POS_W'(PATTERN_MAX);

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_LOW      = 3'd0,
        CFG_PAT_MID_LOW  = 3'd1,
        CFG_PAT_MID_HIGH = 3'd2,
        CFG_PAT_HIGH     = 3'd3,
        CFG_PAT_LEN      = 3'd4
    } t_cfg_reg;

    typedef struct packed {
        logic [7:0] target_char;
        logic       char_present;
        logic       last_char;
    } t_item;

    typedef struct packed {
        logic               matched;
        logic [SCORE_W-1:0] match_score;
    } t_result;

    function automatic logic [7:0] fold_case(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= CH_UP_A && b <= CH_UP_Z) begin
            r = b + 8'd32;
        end
        return r;
    endfunction

    function automatic logic is_separator(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_DASH) || (b == CH_UNDER) || (b == CH_SLASH);
    endfunction

endpackage

>>> src/fss_item_if.sv
// target byte channel: valid/ready with one target byte per transaction
interface fss_item_if;
    logic       valid;
    logic       ready;
    logic [7:0] target_char;
    logic       char_present;
    logic       last_char;

    modport source (output valid, output target_char, output char_present,
                    output last_char, input ready);
    modport sink   (input valid, input target_char, input char_present,
                    input last_char, output ready);
endinterface

>>> src/fss_result_if.sv
// result channel: valid/ready with one match outcome per transaction
interface fss_result_if;
    logic                          valid;
    logic                          ready;
    logic                          matched;
    logic [fss_pkg::SCORE_W-1:0]   match_score;

    modport source (output valid, output matched, output match_score, input ready);
    modport sink   (input valid, input matched, input match_score, output ready);
endinterface

>>> src/fss_core.sv
// per-string match state and one-byte score update
module fss_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_step,
    input  fss_pkg::t_item                    i_item,
    input  logic [fss_pkg::PATTERN_W-1:0]     i_pattern,
    input  logic [fss_pkg::POS_W-1:0]         i_plen,
    output fss_pkg::t_result                  o_result
);

    logic [fss_pkg::POS_W-1:0]   r_pos,    n_pos;
    logic [fss_pkg::RUN_W-1:0]   r_run,    n_run;
    logic [fss_pkg::SCORE_W-1:0] r_score,  n_score;
    logic [7:0]                  r_prev_b, n_prev_b;
    logic                        r_prev_m, n_prev_m;
    logic                        r_start,  n_start;
    logic [fss_pkg::TLEN_W-1:0]  r_tlen,   n_tlen;

    logic [7:0]                  w_pat_byte;
    logic                        w_active;
    logic                        w_hit;
    logic                        w_bound;
    logic [fss_pkg::RUN_W-1:0]   w_run_inc;
    logic [9:0]                  w_run_bonus;
    logic [9:0]                  w_add;
    logic [fss_pkg::SCORE_W:0]   w_sum;
    logic [fss_pkg::TLEN_W-1:0]  w_diff;
    logic [fss_pkg::TLEN_W-1:0]  w_score_ext;

    // pattern byte at the current position, 5 index bits suffice while active
    assign w_pat_byte = i_pattern[{r_pos[fss_pkg::POS_W-2:0], 3'b000} +: 8];
    assign w_active   = i_item.char_present && (r_pos < i_plen);
    assign w_hit      = w_active &&
                        (fss_pkg::fold_case(w_pat_byte) == fss_pkg::fold_case(i_item.target_char));
    assign w_bound    = r_start || fss_pkg::is_separator(r_prev_b);

    always_comb begin
        w_run_inc   = (r_run != fss_pkg::RUN_MAX) ? r_run + 1'b1 : r_run;
        // 15 * run as 16 * run - run
        w_run_bonus = {w_run_inc, 4'b0000} - {4'b0000, w_run_inc};
        w_add       = fss_pkg::HIT_BONUS
                    + (w_bound  ? fss_pkg::EDGE_BONUS : 10'd0)
                    + (r_prev_m ? w_run_bonus : 10'd0);
        w_sum       = {1'b0, r_score} + {5'b00000, w_add};
    end

    always_comb begin
        n_pos    = r_pos;
        n_run    = r_run;
        n_score  = r_score;
        n_prev_m = r_prev_m;
        n_prev_b = r_prev_b;
        n_start  = r_start;
        n_tlen   = r_tlen;
        if (i_item.char_present) begin
            n_prev_b = i_item.target_char;
            n_start  = 1'b0;
            if (r_tlen != fss_pkg::TLEN_MAX) begin
                n_tlen = r_tlen + 1'b1;
            end
        end
        if (w_active) begin
            n_prev_m = w_hit;
        end
        if (w_hit) begin
            n_pos   = r_pos + 1'b1;
            n_run   = r_prev_m ? w_run_inc : '0;
            n_score = w_sum[fss_pkg::SCORE_W] ? fss_pkg::SCORE_MAX
                                              : w_sum[fss_pkg::SCORE_W-1:0];
        end
    end

    // final score from the state after this byte
    always_comb begin
        w_diff      = (n_tlen > fss_pkg::TLEN_W'(i_plen)) ? n_tlen - fss_pkg::TLEN_W'(i_plen) : '0;
        w_score_ext = fss_pkg::TLEN_W'(n_score);
        o_result    = '0;
        if (i_plen == '0) begin
            o_result.matched     = 1'b1;
            o_result.match_score = fss_pkg::EMPTY_SCORE;
        end else if (n_pos >= i_plen) begin
            o_result.matched     = 1'b1;
            o_result.match_score = (w_score_ext > w_diff)
                                 ? fss_pkg::SCORE_W'(w_score_ext - w_diff)
                                 : fss_pkg::SCORE_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_item.last_char)) begin
            r_pos    <= '0;
            r_run    <= '0;
            r_score  <= '0;
            r_prev_b <= '0;
            r_prev_m <= 1'b0;
            r_start  <= 1'b1;
            r_tlen   <= '0;
        end else if (i_step) begin
            r_pos    <= n_pos;
            r_run    <= n_run;
            r_score  <= n_score;
            r_prev_b <= n_prev_b;
            r_prev_m <= n_prev_m;
            r_start  <= n_start;
            r_tlen   <= n_tlen;
        end
    end

`ifndef ASSERT_OFF
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_item.last_char |=> r_pos == '0 && r_tlen == '0 && r_start)
        else $error("string state not cleared after last byte");

    a_hold_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_pos) && $stable(r_score) && $stable(r_tlen))
        else $error("string state changed without a step");

    a_score_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_score != '0 |-> r_pos != '0)
        else $error("nonzero score with no matched pattern character");
`endif

endmodule

>>> src/fuzzy_subsequence_scorer.sv
// top level of the fuzzy subsequence scorer: config registers, input and result stages
//
// usage
//  - s_item carries one target byte per transaction (target_char, char_present,
//    last_char); a byte with char_present low is skipped, as for an empty target string
//  - m_result carries one transaction per target string, produced for the item
//    with last_char set: matched and match_score
//  - the pattern (up to 32 bytes) and its length are written through the plain
//    config port (i_cfg_we, i_cfg_index, i_cfg_data) while the block is idle
// timing
//  - an accepted byte is held in the input register; the score update and the final
//    score are one combinational step into the result register
//  - the last byte of a string waits in the input register, and its outcome is then
//    registered in the result register, which drives m_result
//  - throughput: one byte per cycle, except while a last byte stalls in the input register
// reset and stall
//  - synchronous active-low reset clears the string state, pattern and both stages
//  - while a result waits for m_result.ready, bytes that carry no result still
//    flow; only a second last byte stalls in the input register and s_item.ready
//    drops until the result is taken
module fuzzy_subsequence_scorer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    fss_item_if.sink                          s_item,
    fss_result_if.source                      m_result,
    input  logic                              i_cfg_we,
    input  logic [fss_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fss_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    // pattern registers, one 64-bit word per eight characters
    logic [fss_pkg::CFG_DATA_W-1:0] r_pat [4];
    logic [fss_pkg::POS_W-1:0]      r_plen;
    logic [fss_pkg::POS_W-1:0]      w_plen;
    logic [fss_pkg::PATTERN_W-1:0]  w_pattern;

    // input stage
    logic                 r_in_valid;
    fss_pkg::t_item       r_in;

    // result stage
    logic                 r_out_valid;
    fss_pkg::t_result     r_out;

    fss_pkg::t_result     w_result;
    logic                 w_out_free;
    logic                 w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat[0] <= '0;
            r_pat[1] <= '0;
            r_pat[2] <= '0;
            r_pat[3] <= '0;
            r_plen   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fss_pkg::CFG_PAT_LOW:      r_pat[0] <= i_cfg_data;
                fss_pkg::CFG_PAT_MID_LOW:  r_pat[1] <= i_cfg_data;
                fss_pkg::CFG_PAT_MID_HIGH: r_pat[2] <= i_cfg_data;
                fss_pkg::CFG_PAT_HIGH:     r_pat[3] <= i_cfg_data;
                fss_pkg::CFG_PAT_LEN:      r_plen   <= i_cfg_data[fss_pkg::POS_W-1:0];
                default: begin
                    // unused index, write ignored
                end
            endcase
        end
    end

    // lengths above the pattern capacity count as full capacity
    assign w_plen    = (r_plen > fss_pkg::PLEN_MAX) ? fss_pkg::PLEN_MAX : r_plen;
    assign w_pattern = {r_pat[3], r_pat[2], r_pat[1], r_pat[0]};

    // a byte without a result always moves on; a last byte needs room downstream
    assign w_out_free   = !r_out_valid || m_result.ready;
    assign w_adv        = r_in_valid && (!r_in.last_char || w_out_free);
    assign s_item.ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_item.valid && s_item.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_item.valid && s_item.ready) begin
            r_in.target_char  <= s_item.target_char;
            r_in.char_present <= s_item.char_present;
            r_in.last_char    <= s_item.last_char;
        end
    end

    fss_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_adv),
        .i_item    (r_in),
        .i_pattern (w_pattern),
        .i_plen    (w_plen),
        .o_result  (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && r_in.last_char) begin
            r_out_valid <= 1'b1;
        end else if (m_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in.last_char) begin
            r_out <= w_result;
        end
    end

    assign m_result.valid       = r_out_valid;
    assign m_result.matched     = r_out.matched;
    assign m_result.match_score = r_out.match_score;

`ifndef ASSERT_OFF
    a_nomatch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.matched |-> r_out.match_score == '0)
        else $error("no-match result with nonzero score");

    a_match_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.matched |-> r_out.match_score != '0)
        else $error("match result with zero score");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_item.ready |-> r_in_valid && r_in.last_char && r_out_valid && !m_result.ready)
        else $error("input stalled without a pending result");
`endif

endmodule

>>> dv/fss_score_checker.sv
`timescale 1ns / 1ps
// scoreboard for the fuzzy subsequence scorer: predicts each string outcome and compares it
module fss_score_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_item_valid,
    input  logic                         i_item_ready,
    input  logic [7:0]                   i_target_char,
    input  logic                         i_char_present,
    input  logic                         i_last_char,
    input  logic                         i_res_valid,
    input  logic                         i_res_ready,
    input  logic                         i_matched,
    input  logic [fss_pkg::SCORE_W-1:0]  i_match_score,
    input  logic                         i_cfg_we,
    input  logic [fss_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [fss_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                           o_fail_count,
    output int                           o_pending
);
    import fss_pkg::*;

    localparam int REPORT_LIMIT = 10;
    localparam int RUN_STEP     = 15;

    t_result                pending_outcomes [$];
    logic [CFG_DATA_W-1:0]  pat_words [4];
    logic [POS_W-1:0]       len_reg;
    logic [POS_W-1:0]       match_pos;
    logic [RUN_W-1:0]       run_len;
    logic [SCORE_W-1:0]     score_acc;
    logic [7:0]             prior_byte;
    logic                   prior_hit;
    logic                   at_start;
    logic [TLEN_W-1:0]      target_len;

    function automatic logic [7:0] lower_byte(input logic [7:0] b);
        if (b >= CH_UP_A && b <= CH_UP_Z) begin
            return b | 8'h20;
        end
        return b;
    endfunction

    task automatic add_score(input int amount);
        int total;
        total = int'(score_acc) + amount;
        score_acc = (total > int'(SCORE_MAX)) ? SCORE_MAX : SCORE_W'(total);
    endtask

    task automatic clear_string();
        match_pos  = '0;
        run_len    = '0;
        score_acc  = '0;
        prior_byte = '0;
        prior_hit  = 1'b0;
        at_start   = 1'b1;
        target_len = '0;
    endtask

    task automatic score_target_byte(input logic [7:0] ch, input logic present,
                                     input logic last);
        int         plen;
        int         diff;
        logic [7:0] pat_byte;
        t_result    outcome;
        plen = (int'(len_reg) > PATTERN_MAX) ? PATTERN_MAX : int'(len_reg);
        if (present) begin
            if (target_len != TLEN_MAX) begin
                target_len++;
            end
            if (int'(match_pos) < plen) begin
                pat_byte = pat_words[match_pos[4:3]][{match_pos[2:0], 3'b000} +: 8];
                if (lower_byte(pat_byte) == lower_byte(ch)) begin
                    add_score(HIT_BONUS);
                    if (at_start || prior_byte == CH_SPACE || prior_byte == CH_DASH ||
                        prior_byte == CH_UNDER || prior_byte == CH_SLASH) begin
                        add_score(EDGE_BONUS);
                    end
                    if (prior_hit) begin
                        if (run_len != RUN_MAX) begin
                            run_len++;
                        end
                        add_score(RUN_STEP * int'(run_len));
                    end else begin
                        run_len = '0;
                    end
                    match_pos++;
                    prior_hit = 1'b1;
                end else begin
                    prior_hit = 1'b0;
                end
            end
            prior_byte = ch;
            at_start   = 1'b0;
        end
        if (last) begin
            outcome.matched     = 1'b0;
            outcome.match_score = '0;
            if (plen == 0) begin
                outcome.matched     = 1'b1;
                outcome.match_score = EMPTY_SCORE;
            end else if (int'(match_pos) >= plen) begin
                diff = (int'(target_len) > plen) ? int'(target_len) - plen : 0;
                outcome.matched     = 1'b1;
                outcome.match_score = (int'(score_acc) > diff) ?
                                      SCORE_W'(int'(score_acc) - diff) : SCORE_W'(1);
            end
            pending_outcomes.push_back(outcome);
            clear_string();
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            pending_outcomes.delete();
            foreach (pat_words[k]) begin
                pat_words[k] = '0;
            end
            len_reg = '0;
            clear_string();
        end else begin
            // results first: a result never belongs to the byte taken at this edge
            if (i_res_valid && i_res_ready) begin
                got.matched     = i_matched;
                got.match_score = i_match_score;
                if (pending_outcomes.size() == 0) begin
                    if (o_fail_count < REPORT_LIMIT) begin
                        $display("%0t: unexpected result matched=%0b score=%0d",
                                 $time, got.matched, got.match_score);
                    end
                    o_fail_count++;
                end else begin
                    want = pending_outcomes.pop_front();
                    if (got.matched !== want.matched || got.match_score !== want.match_score) begin
                        if (o_fail_count < REPORT_LIMIT) begin
                            $display("%0t: result mismatch, expected matched=%0b score=%0d, got matched=%0b score=%0d",
                                     $time, want.matched, want.match_score,
                                     got.matched, got.match_score);
                        end
                        o_fail_count++;
                    end
                end
            end
            if (i_item_valid && i_item_ready) begin
                score_target_byte(i_target_char, i_char_present, i_last_char);
            end
            // register writes count from the next byte on
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PAT_LOW:      pat_words[0] = i_cfg_data;
                    CFG_PAT_MID_LOW:  pat_words[1] = i_cfg_data;
                    CFG_PAT_MID_HIGH: pat_words[2] = i_cfg_data;
                    CFG_PAT_HIGH:     pat_words[3] = i_cfg_data;
                    CFG_PAT_LEN:      len_reg = i_cfg_data[POS_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending = pending_outcomes.size();
    end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// testbench top for the fuzzy subsequence scorer: clock, reset, stimulus and verdict
module tb;
    import fss_pkg::*;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 10;
    localparam int HOLD_CYCLES   = 64;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_COUNT   = 8;
    localparam int PHASE_ITEMS   = 60;
    localparam int TIMEOUT_NS    = 2_000_000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int  fail_count;
    int  pending_count;
    // idle knobs, in percent of cycles
    int  send_idle_pct;
    int  recv_stall_pct;
    // chance of a byte with char_present low inside a string
    int  absent_pct;
    bit  hold_req;
    int  sent_items;

    logic [7:0] pat_buf [PATTERN_MAX];
    logic [7:0] tgt_q [$];

    fss_item_if   u_item_if ();
    fss_result_if u_result_if ();

    fuzzy_subsequence_scorer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_item      (u_item_if),
        .m_result    (u_result_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    fss_score_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item_valid   (u_item_if.valid),
        .i_item_ready   (u_item_if.ready),
        .i_target_char  (u_item_if.target_char),
        .i_char_present (u_item_if.char_present),
        .i_last_char    (u_item_if.last_char),
        .i_res_valid    (u_result_if.valid),
        .i_res_ready    (u_result_if.ready),
        .i_matched      (u_result_if.matched),
        .i_match_score  (u_result_if.match_score),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending_count)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // hard stop in case the block hangs
    initial begin
        #(TIMEOUT_NS);
        $display("Mismatches found");
        $finish;
    end

    // result receiver: random stalls, plus one long hold-off on request so that
    // the block fills up and drops s_item.ready
    initial begin : receiver
        u_result_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                repeat (HOLD_CYCLES) begin
                    u_result_if.ready <= 1'b0;
                    @(negedge i_clk);
                end
            end
            u_result_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // random filler byte, separators get a boost so the edge bonus shows up often
    function automatic logic [7:0] random_filler();
        logic [7:0] seps [4];
        seps = '{CH_SPACE, CH_DASH, CH_UNDER, CH_SLASH};
        if ($urandom_range(0, 2) == 0) begin
            return seps[$urandom_range(0, 3)];
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pattern_word(input int k);
        logic [CFG_DATA_W-1:0] w;
        for (int j = 0; j < 8; j++) begin
            w[j*8 +: 8] = pat_buf[k*8 + j];
        end
        return w;
    endfunction

    // one byte transaction; called and returning at a falling edge
    task automatic send_byte(input logic [7:0] ch, input logic present, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            u_item_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        u_item_if.valid        <= 1'b1;
        u_item_if.target_char  <= ch;
        u_item_if.char_present <= present;
        u_item_if.last_char    <= last;
        do @(posedge i_clk); while (!u_item_if.ready);
        @(negedge i_clk);
        sent_items++;
    endtask

    // sends tgt_q as one string; an empty queue becomes an empty target
    task automatic send_target();
        bit absent_tail;
        if (tgt_q.size() == 0) begin
            send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end else begin
            // sometimes the string is closed by a byte that is not present
            absent_tail = ($urandom_range(0, 99) < 2 * absent_pct);
            foreach (tgt_q[i]) begin
                if ($urandom_range(0, 99) < absent_pct) begin
                    send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                end
                send_byte(tgt_q[i], 1'b1, !absent_tail && (i == tgt_q.size() - 1));
            end
            if (absent_tail) begin
                send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            end
        end
    endtask

    task automatic send_text(input string s);
        tgt_q.delete();
        for (int i = 0; i < s.len(); i++) begin
            tgt_q.push_back(s[i]);
        end
        send_target();
    endtask

    task automatic load_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            pat_buf[i] = s[i];
        end
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge i_clk);
    endtask

    // all four pattern words and the length, back to back
    task automatic program_pattern(input int len_value);
        write_reg(CFG_PAT_LOW,      pattern_word(0));
        write_reg(CFG_PAT_MID_LOW,  pattern_word(1));
        write_reg(CFG_PAT_MID_HIGH, pattern_word(2));
        write_reg(CFG_PAT_HIGH,     pattern_word(3));
        write_reg(CFG_PAT_LEN,      CFG_DATA_W'(len_value));
        cfg_we <= 1'b0;
    endtask

    // block idle: input quiet, every outcome back, then a settling margin
    task automatic wait_drained();
        u_item_if.valid <= 1'b0;
        while (pending_count != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin : stimulus
        int         plen_reg;
        int         eff_len;
        int         kind;
        int         fill_n;
        int         phase_start;
        int         phase_strings;
        int         min_strings;
        logic [7:0] b;

        u_item_if.valid        = 1'b0;
        u_item_if.target_char  = '0;
        u_item_if.char_present = 1'b0;
        u_item_if.last_char    = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_PAT_LOW;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        absent_pct     = 0;
        hold_req       = 1'b0;
        sent_items     = 0;
        foreach (pat_buf[i]) begin
            pat_buf[i] = '0;
        end

        i_rst_n = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // ---- directed strings ----
        // case folding and the bonus after underscore, dash and slash
        load_text("abc");
        program_pattern(3);
        send_text("_A-b/C");
        // empty target against a non-empty pattern
        send_byte(8'h5A, 1'b0, 1'b1);
        // pattern left unfinished, string closed by a byte that is not present
        send_byte("a", 1'b1, 1'b0);
        send_byte("b", 1'b1, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b1);

        // empty pattern scores 100 whatever the target
        wait_drained();
        program_pattern(0);
        send_text("q");

        // zero byte inside the pattern is an ordinary character; adjacent run
        wait_drained();
        pat_buf[0] = 8'h00;
        pat_buf[1] = 8'hFF;
        program_pattern(2);
        tgt_q = {8'h00, 8'hFF};
        send_target();

        // long excess over the pattern length pushes the score down to the floor
        wait_drained();
        load_text("q");
        program_pattern(1);
        send_text("xxxxxxxxxqx");

        // ---- back-pressure: long receiver hold with single-byte strings queued up ----
        wait_drained();
        load_text("a");
        program_pattern(1);
        hold_req = 1'b1;
        repeat (24) begin
            send_byte($urandom_range(0, 1) ? 8'h61 : 8'($urandom_range(0, 255)), 1'b1, 1'b1);
        end

        // ---- random phases: idle mode and pattern setting change per phase ----
        absent_pct = 5;
        for (int p = 0; p < PHASE_COUNT; p++) begin
            wait_drained();
            case (p % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 47;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 47;
                end
                default: begin
                    send_idle_pct  = 16;
                    recv_stall_pct = 16;
                end
            endcase
            // length register: small, empty, above the maximum, full, single
            case (p)
                0:       plen_reg = $urandom_range(1, 6);
                1:       plen_reg = 0;
                2:       plen_reg = 63;
                3:       plen_reg = PATTERN_MAX;
                4:       plen_reg = 1;
                default: plen_reg = $urandom_range(1, 8);
            endcase
            // mostly letters in either case, a few raw bytes; one phase of all
            // zero and all one bytes
            for (int i = 0; i < PATTERN_MAX; i++) begin
                b = 8'($urandom_range(0, 255));
                if (p == 6) begin
                    b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                end else if ($urandom_range(0, 7) != 0) begin
                    b = 8'h61 + 8'($urandom_range(0, 25));
                    if ($urandom_range(0, 1) != 0) begin
                        b = b - 8'h20;
                    end
                end
                pat_buf[i] = b;
            end
            program_pattern(plen_reg);
            eff_len = (plen_reg > PATTERN_MAX) ? PATTERN_MAX : plen_reg;
            // long patterns make long strings, so fewer of them
            min_strings = (eff_len > 16) ? 3 : 6;
            phase_start = sent_items;
            phase_strings = 0;
            while (sent_items - phase_start < PHASE_ITEMS || phase_strings < min_strings) begin
                kind = $urandom_range(0, 9);
                tgt_q.delete();
                if (kind == 0 || eff_len == 0) begin
                    // pure noise string, possibly empty
                    repeat ($urandom_range(0, 12)) tgt_q.push_back(random_filler());
                end else begin
                    // pattern characters in order with filler between them
                    for (int k = 0; k < eff_len; k++) begin
                        // broken string: some pattern characters go missing
                        if (kind == 1 && $urandom_range(0, 3) == 0) begin
                            continue;
                        end
                        if (eff_len > 8) begin
                            fill_n = ($urandom_range(0, 3) == 0) ? 1 : 0;
                        end else begin
                            fill_n = $urandom_range(0, 3);
                        end
                        repeat (fill_n) tgt_q.push_back(random_filler());
                        b = pat_buf[k];
                        // flip the case of letters at random
                        if ((b | 8'h20) >= "a" && (b | 8'h20) <= "z" &&
                            $urandom_range(0, 1) != 0) begin
                            b = b ^ 8'h20;
                        end
                        tgt_q.push_back(b);
                    end
                    // trailing bytes only add length, long tails hit the floor of 1
                    if ($urandom_range(0, 3) == 0) begin
                        repeat ($urandom_range(1, 15)) tgt_q.push_back(random_filler());
                    end
                end
                send_target();
                phase_strings++;
            end
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
